// ===== rtl/ctrb_pkg.sv =====
// ----------------------------------------------------------------------------
// ctrb_pkg
// Shared constants, item codes and the fixed palette for the clipped tile
// and rectangle blitter.
// ----------------------------------------------------------------------------
package ctrb_pkg;

  // Default geometry
  localparam int SCREEN_W_DEF = 160;
  localparam int SCREEN_H_DEF = 144;
  localparam int ATLAS_W_DEF  = 128;
  localparam int ATLAS_H_DEF  = 128;
  localparam int TILE_DEF     = 8;

  // Field widths
  localparam int KIND_W  = 3;
  localparam int COORD_W = 9;
  localparam int COLOR_W = 2;
  localparam int TPOS_W  = 4;
  localparam int LADDR_W = 14;
  localparam int LVAL_W  = 8;
  localparam int RGB_W   = 24;
  localparam int CFG_W   = 8;
  localparam int CIDX_W  = 2;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FILL  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_BLIT  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_LOAD  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ  = 3'd4;

  // Register indexes
  localparam logic [CIDX_W-1:0] REG_CLIP_LEFT   = 2'd0;
  localparam logic [CIDX_W-1:0] REG_CLIP_TOP    = 2'd1;
  localparam logic [CIDX_W-1:0] REG_CLIP_RIGHT  = 2'd2;
  localparam logic [CIDX_W-1:0] REG_CLIP_BOTTOM = 2'd3;

  // Register reset values
  localparam logic [CFG_W-1:0] CLIP_LEFT_RST   = 8'd0;
  localparam logic [CFG_W-1:0] CLIP_TOP_RST    = 8'd0;
  localparam logic [CFG_W-1:0] CLIP_RIGHT_RST  = 8'd159;
  localparam logic [CFG_W-1:0] CLIP_BOTTOM_RST = 8'd143;

  // Atlas values at or above this are transparent
  localparam logic [LVAL_W-1:0] TRANSPARENT_MIN = 8'd4;

  // Fixed four-entry palette
  function automatic logic [RGB_W-1:0] palette_rgb(input logic [COLOR_W-1:0] idx);
    logic [RGB_W-1:0] rgb;
    unique case (idx)
      2'd0: rgb = 24'h9bbc0f;
      2'd1: rgb = 24'h8bac0f;
      2'd2: rgb = 24'h306230;
      2'd3: rgb = 24'h0f380f;
    endcase
    return rgb;
  endfunction

endpackage

// ===== rtl/clipped_tile_and_rect_blitter_core.sv =====
// ----------------------------------------------------------------------------
// clipped_tile_and_rect_blitter_core
// 2D blitter over a frame store of palette indices and a tile atlas store:
// clear, clipped fill, clipped tile blit, atlas load and pixel read.
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_ready    kind .. atlas_value
//   out      output     out_valid/out_ready  pixel_rgb, is_read_data
//   cfg      input      cfg_we               cfg_idx, cfg_wdata
//
// One item is worked on at a time; each passes through decode (S_PREP) and
// address setup (S_SETUP), then its memory sweep: clear writes every frame
// address, fill writes each covered pixel, tile blit reads one atlas word per
// cycle feeding at most one frame write, load writes one atlas word and read
// reads one frame word. After reset the frame store is swept to zero and no
// word is accepted; configuration writes are taken throughout.
// The result word waits in an output register; a new word is accepted
// while it waits, and the item only stalls at its end if it is still there.
// ----------------------------------------------------------------------------
module clipped_tile_and_rect_blitter_core #(
  parameter int SCREEN_W = ctrb_pkg::SCREEN_W_DEF,
  parameter int SCREEN_H = ctrb_pkg::SCREEN_H_DEF,
  parameter int ATLAS_W  = ctrb_pkg::ATLAS_W_DEF,
  parameter int ATLAS_H  = ctrb_pkg::ATLAS_H_DEF,
  parameter int TILE     = ctrb_pkg::TILE_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input words
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [ctrb_pkg::KIND_W-1:0]         kind_i,
  input  logic signed [ctrb_pkg::COORD_W-1:0] x_min_i,
  input  logic signed [ctrb_pkg::COORD_W-1:0] y_min_i,
  input  logic signed [ctrb_pkg::COORD_W-1:0] x_max_i,
  input  logic signed [ctrb_pkg::COORD_W-1:0] y_max_i,
  input  logic [ctrb_pkg::COLOR_W-1:0]        color_index_i,
  input  logic [ctrb_pkg::TPOS_W-1:0]         tile_col_i,
  input  logic [ctrb_pkg::TPOS_W-1:0]         tile_row_i,
  input  logic [ctrb_pkg::LADDR_W-1:0]        atlas_address_i,
  input  logic [ctrb_pkg::LVAL_W-1:0]         atlas_value_i,
  // result words
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [ctrb_pkg::RGB_W-1:0]          pixel_rgb_o,
  output logic                                is_read_data_o,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [ctrb_pkg::CIDX_W-1:0]         cfg_idx_i,
  input  logic [ctrb_pkg::CFG_W-1:0]          cfg_wdata_i
);

  localparam int FRAME_DEPTH = SCREEN_W * SCREEN_H;
  localparam int ATLAS_DEPTH = ATLAS_W * ATLAS_H;
  localparam int FA_W        = $clog2(FRAME_DEPTH);
  localparam int AA_W        = $clog2(ATLAS_DEPTH);
  localparam int TW          = $clog2(TILE);
  localparam int SIDE_BITS   = $clog2(((SCREEN_W > SCREEN_H) ? SCREEN_W : SCREEN_H) + 1);
  localparam int CW          = ((SIDE_BITS > ctrb_pkg::COORD_W) ?
                                SIDE_BITS : ctrb_pkg::COORD_W) + 2;
  localparam int MW          = (FA_W > CW) ? FA_W : CW;
  localparam int TILES_X     = ATLAS_W / TILE;
  localparam int TILES_Y     = ATLAS_H / TILE;
  localparam int ATLAS_TSTEP = TILE * ATLAS_W;

  localparam logic signed [CW-1:0] SW_S   = CW'(SCREEN_W);
  localparam logic signed [CW-1:0] SH_S   = CW'(SCREEN_H);
  localparam logic signed [CW-1:0] XLAST  = CW'(SCREEN_W - 1);
  localparam logic signed [CW-1:0] YLAST  = CW'(SCREEN_H - 1);
  localparam logic [FA_W-1:0]      FLAST  = FA_W'(FRAME_DEPTH - 1);
  localparam logic [FA_W-1:0]      FSTEP  = FA_W'(SCREEN_W);
  localparam logic [MW-1:0]        FSTEP_M = MW'(SCREEN_W);
  localparam logic [AA_W-1:0]      ASTEP  = AA_W'(ATLAS_W);
  localparam logic [TW-1:0]        TMAX   = TW'(TILE - 1);

  typedef enum logic [8:0] {
    S_INIT   = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_PREP   = 9'b000000100,
    S_SETUP  = 9'b000001000,
    S_CLEAR  = 9'b000010000,
    S_FILL   = 9'b000100000,
    S_BLIT   = 9'b001000000,
    S_RDWAIT = 9'b010000000,
    S_FINISH = 9'b100000000
  } state_e;

  // Control state
  state_e state_q, state_d;
  logic [FA_W-1:0] clr_q, clr_d;
  logic issue_done_q, issue_done_d;
  logic p_valid_q, p_valid_d;
  logic out_valid_q, out_valid_d;
  logic [ctrb_pkg::CFG_W-1:0] clip_left_q, clip_top_q, clip_right_q, clip_bottom_q;

  // Latched item
  logic [ctrb_pkg::KIND_W-1:0]   kind_q;
  logic signed [CW-1:0]          x0_q, y0_q, x1_q, y1_q;
  logic [ctrb_pkg::COLOR_W-1:0]  color_q;
  logic [ctrb_pkg::TPOS_W-1:0]   tcol_q, trow_q;
  logic [ctrb_pkg::LADDR_W-1:0]  ld_addr_q;
  logic [ctrb_pkg::LVAL_W-1:0]   ld_val_q;

  // Datapath state
  logic signed [CW-1:0] mx_q, mx_d, my_q, my_d;
  logic signed [CW-1:0] xs_q, xs_d, xe_q, xe_d, ye_q, ye_d;
  logic signed [CW-1:0] cx_q, cx_d, cy_q, cy_d;
  logic empty_q, empty_d;
  logic [FA_W-1:0] faddr_q, faddr_d, frow_q, frow_d;
  logic [AA_W-1:0] arow_q, arow_d;
  logic [TW-1:0]   ox_q, ox_d, oy_q, oy_d;
  logic signed [CW-1:0] p_x_q, p_x_d, p_y_q, p_y_d;
  logic [FA_W-1:0] p_faddr_q, p_faddr_d;
  logic [ctrb_pkg::RGB_W-1:0] res_rgb_q, res_rgb_d, pixel_rgb_q, pixel_rgb_d;
  logic res_rd_q, res_rd_d, is_read_q, is_read_d;

  // Combinational helpers
  logic in_fire;
  logic signed [CW-1:0] clip_l_s, clip_t_s, x_hi_s, y_hi_s;
  logic signed [CW-1:0] x1m, y1m, xs, xe, ys, ye;
  logic [MW-1:0] mx_ext, my_ext, base_m;
  logic [FA_W-1:0] base_f;
  logic [AA_W-1:0] atlas_base;
  logic tile_ok, load_ok, on_screen, p_in_win;

  // Memory ports
  logic fw_en, fr_en;
  logic [FA_W-1:0] fw_addr, fr_addr;
  logic [ctrb_pkg::COLOR_W-1:0] fw_data;
  logic [ctrb_pkg::RGB_W-1:0] fr_rgb;
  logic at_we, at_re;
  logic [AA_W-1:0] at_raddr;
  logic [ctrb_pkg::LVAL_W-1:0] atlas_mem [ATLAS_DEPTH];
  logic [ctrb_pkg::LVAL_W-1:0] atlas_rd_q;

  assign in_ready_o     = (state_q == S_IDLE);
  assign in_fire        = in_valid_i && in_ready_o;
  assign out_valid_o    = out_valid_q;
  assign pixel_rgb_o    = pixel_rgb_q;
  assign is_read_data_o = is_read_q;

  // Effective clip window, limited to the screen
  assign clip_l_s = $signed(CW'(clip_left_q));
  assign clip_t_s = $signed(CW'(clip_top_q));
  assign x_hi_s   = ($signed(CW'(clip_right_q)) < XLAST) ? $signed(CW'(clip_right_q)) : XLAST;
  assign y_hi_s   = ($signed(CW'(clip_bottom_q)) < YLAST) ? $signed(CW'(clip_bottom_q)) : YLAST;

  // Clipped fill bounds
  assign x1m = CW'(x1_q - 1);
  assign y1m = CW'(y1_q - 1);
  assign xs  = (x0_q > clip_l_s) ? x0_q : clip_l_s;
  assign ys  = (y0_q > clip_t_s) ? y0_q : clip_t_s;
  assign xe  = (x1m < x_hi_s) ? x1m : x_hi_s;
  assign ye  = (y1m < y_hi_s) ? y1m : y_hi_s;

  // Row-major frame address of the prepared corner, truncated to the address width
  assign mx_ext = MW'(mx_q);
  assign my_ext = MW'(my_q);
  assign base_m = my_ext * FSTEP_M + mx_ext;
  assign base_f = base_m[FA_W-1:0];

  assign atlas_base = AA_W'(32'(trow_q) * ATLAS_TSTEP + 32'(tcol_q) * TILE);
  assign tile_ok    = (32'(tcol_q) < TILES_X) && (32'(trow_q) < TILES_Y);
  assign load_ok    = (32'(ld_addr_q) < ATLAS_DEPTH);
  assign on_screen  = (x0_q >= 0) && (y0_q >= 0) && (x0_q < SW_S) && (y0_q < SH_S);
  assign p_in_win   = (p_x_q >= clip_l_s) && (p_x_q <= x_hi_s) &&
                      (p_y_q >= clip_t_s) && (p_y_q <= y_hi_s);

  // Sequencer
  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    issue_done_d = issue_done_q;
    p_valid_d    = p_valid_q;
    out_valid_d  = out_valid_q;
    mx_d = mx_q;  my_d = my_q;
    xs_d = xs_q;  xe_d = xe_q;  ye_d = ye_q;
    cx_d = cx_q;  cy_d = cy_q;
    empty_d   = empty_q;
    faddr_d   = faddr_q;
    frow_d    = frow_q;
    arow_d    = arow_q;
    ox_d = ox_q;  oy_d = oy_q;
    p_x_d = p_x_q;  p_y_d = p_y_q;
    p_faddr_d   = p_faddr_q;
    res_rgb_d   = res_rgb_q;
    res_rd_d    = res_rd_q;
    pixel_rgb_d = pixel_rgb_q;
    is_read_d   = is_read_q;
    fw_en   = 1'b0;
    fw_addr = clr_q;
    fw_data = color_q;
    fr_en   = 1'b0;
    fr_addr = base_f;
    at_we   = 1'b0;
    at_re   = 1'b0;
    at_raddr = arow_q + AA_W'(ox_q);

    // Drop the result word once taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_INIT: begin
        fw_en   = 1'b1;
        fw_data = '0;
        clr_d   = clr_q + 1'b1;
        if (clr_q == FLAST) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        xs_d    = xs;
        xe_d    = xe;
        ye_d    = ye;
        cx_d    = xs;
        cy_d    = ys;
        empty_d = (xs > xe) || (ys > ye);
        if (kind_q == ctrb_pkg::KIND_FILL) begin
          mx_d = xs;
          my_d = ys;
        end else begin
          mx_d = x0_q;
          my_d = y0_q;
        end
        state_d = S_SETUP;
      end
      S_SETUP: begin
        res_rgb_d = '0;
        res_rd_d  = (kind_q == ctrb_pkg::KIND_READ);
        state_d   = S_FINISH;
        unique case (kind_q)
          ctrb_pkg::KIND_CLEAR: begin
            clr_d   = '0;
            state_d = S_CLEAR;
          end
          ctrb_pkg::KIND_FILL: begin
            faddr_d = base_f;
            frow_d  = base_f;
            if (!empty_q) begin
              state_d = S_FILL;
            end
          end
          ctrb_pkg::KIND_BLIT: begin
            frow_d       = base_f;
            arow_d       = atlas_base;
            ox_d         = '0;
            oy_d         = '0;
            issue_done_d = 1'b0;
            p_valid_d    = 1'b0;
            if (tile_ok) begin
              state_d = S_BLIT;
            end
          end
          ctrb_pkg::KIND_LOAD: begin
            at_we = load_ok;
          end
          ctrb_pkg::KIND_READ: begin
            if (on_screen) begin
              fr_en   = 1'b1;
              state_d = S_RDWAIT;
            end
          end
          default: begin
            state_d = S_FINISH;
          end
        endcase
      end
      S_CLEAR: begin
        fw_en = 1'b1;
        clr_d = clr_q + 1'b1;
        if (clr_q == FLAST) begin
          state_d = S_FINISH;
        end
      end
      S_FILL: begin
        fw_en   = 1'b1;
        fw_addr = faddr_q;
        // Advance along the row, then to the next row start
        if (cx_q == xe_q) begin
          if (cy_q == ye_q) begin
            state_d = S_FINISH;
          end else begin
            cy_d    = cy_q + 1'b1;
            cx_d    = xs_q;
            frow_d  = frow_q + FSTEP;
            faddr_d = frow_q + FSTEP;
          end
        end else begin
          cx_d    = cx_q + 1'b1;
          faddr_d = faddr_q + 1'b1;
        end
      end
      S_BLIT: begin
        // Write stage: atlas word read last cycle
        fw_en   = p_valid_q && (atlas_rd_q < ctrb_pkg::TRANSPARENT_MIN) && p_in_win;
        fw_addr = p_faddr_q;
        fw_data = atlas_rd_q[ctrb_pkg::COLOR_W-1:0];
        // Issue stage: one atlas read per cycle
        if (!issue_done_q) begin
          at_re     = 1'b1;
          p_valid_d = 1'b1;
          p_x_d     = x0_q + CW'($signed({1'b0, ox_q}));
          p_y_d     = y0_q + CW'($signed({1'b0, oy_q}));
          p_faddr_d = frow_q + FA_W'(ox_q);
          if (ox_q == TMAX) begin
            ox_d   = '0;
            frow_d = frow_q + FSTEP;
            arow_d = arow_q + ASTEP;
            if (oy_q == TMAX) begin
              issue_done_d = 1'b1;
            end else begin
              oy_d = oy_q + 1'b1;
            end
          end else begin
            ox_d = ox_q + 1'b1;
          end
        end else begin
          p_valid_d = 1'b0;
          state_d   = S_FINISH;
        end
      end
      S_RDWAIT: begin
        res_rgb_d = fr_rgb;
        state_d   = S_FINISH;
      end
      S_FINISH: begin
        // Hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          pixel_rgb_d = res_rgb_q;
          is_read_d   = res_rd_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_INIT;
      clr_q        <= '0;
      issue_done_q <= 1'b0;
      p_valid_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      issue_done_q <= issue_done_d;
      p_valid_q    <= p_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Clip window registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_left_q   <= ctrb_pkg::CLIP_LEFT_RST;
      clip_top_q    <= ctrb_pkg::CLIP_TOP_RST;
      clip_right_q  <= ctrb_pkg::CLIP_RIGHT_RST;
      clip_bottom_q <= ctrb_pkg::CLIP_BOTTOM_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ctrb_pkg::REG_CLIP_LEFT:   clip_left_q   <= cfg_wdata_i;
        ctrb_pkg::REG_CLIP_TOP:    clip_top_q    <= cfg_wdata_i;
        ctrb_pkg::REG_CLIP_RIGHT:  clip_right_q  <= cfg_wdata_i;
        ctrb_pkg::REG_CLIP_BOTTOM: clip_bottom_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Latch the accepted word
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q    <= kind_i;
      x0_q      <= CW'(x_min_i);
      y0_q      <= CW'(y_min_i);
      x1_q      <= CW'(x_max_i);
      y1_q      <= CW'(y_max_i);
      color_q   <= color_index_i;
      tcol_q    <= tile_col_i;
      trow_q    <= tile_row_i;
      ld_addr_q <= atlas_address_i;
      ld_val_q  <= atlas_value_i;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    mx_q <= mx_d;  my_q <= my_d;
    xs_q <= xs_d;  xe_q <= xe_d;  ye_q <= ye_d;
    cx_q <= cx_d;  cy_q <= cy_d;
    empty_q     <= empty_d;
    faddr_q     <= faddr_d;
    frow_q      <= frow_d;
    arow_q      <= arow_d;
    ox_q        <= ox_d;
    oy_q        <= oy_d;
    p_x_q       <= p_x_d;
    p_y_q       <= p_y_d;
    p_faddr_q   <= p_faddr_d;
    res_rgb_q   <= res_rgb_d;
    res_rd_q    <= res_rd_d;
    pixel_rgb_q <= pixel_rgb_d;
    is_read_q   <= is_read_d;
  end

  // Atlas store: load writes, blit reads
  always_ff @(posedge clk_i) begin
    if (at_we) begin
      atlas_mem[AA_W'(ld_addr_q)] <= ld_val_q;
    end
    if (at_re) begin
      atlas_rd_q <= atlas_mem[at_raddr];
    end
  end

  ctrb_frame_store #(
    .DEPTH (FRAME_DEPTH),
    .AW    (FA_W)
  ) u_frame (
    .clk_i   (clk_i),
    .we_i    (fw_en),
    .waddr_i (fw_addr),
    .wdata_i (fw_data),
    .re_i    (fr_en),
    .raddr_i (fr_addr),
    .rgb_o   (fr_rgb)
  );

`ifndef NO_ASSERTIONS
  // Frame writes stay inside the store
  a_fw_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fw_en |-> (32'(fw_addr) < FRAME_DEPTH))
    else $error("frame write address beyond the store");

  // An accepted word starts work at once
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == S_PREP) && !in_ready_o)
    else $error("accepted word did not start work");

  // A result word appears only at the end of an item
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_FINISH))
    else $error("result word without a finished item");

  // No frame or atlas writes while waiting for a word
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !fw_en && !at_we)
    else $error("store written while idle");
`endif

endmodule

// ===== rtl/ctrb_frame_store.sv =====
// ----------------------------------------------------------------------------
// ctrb_frame_store
// Frame store of two-bit palette indices: one write port, one read port with
// registered read data, and the palette lookup on the read side.
// ----------------------------------------------------------------------------
module ctrb_frame_store #(
  parameter int DEPTH = ctrb_pkg::SCREEN_W_DEF * ctrb_pkg::SCREEN_H_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AW-1:0]              waddr_i,
  input  logic [ctrb_pkg::COLOR_W-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [AW-1:0]              raddr_i,
  output logic [ctrb_pkg::RGB_W-1:0] rgb_o
);

  logic [ctrb_pkg::COLOR_W-1:0] mem_q [DEPTH];
  logic [ctrb_pkg::COLOR_W-1:0] rd_idx_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_idx_q <= mem_q[raddr_i];
    end
  end

  // Map the stored index through the palette
  assign rgb_o = ctrb_pkg::palette_rgb(rd_idx_q);

endmodule
